// ===== sv/bpas_pkg.sv =====
// Package for the button pulse and auto power-on sequencer.
// Holds command codes, register indexes, field widths and register reset values.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package bpas_pkg;

    // Field widths fixed by the item format.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int MS_W    = 16;
    localparam int MV_W    = 16;
    localparam int EDGE_W  = 8;
    localparam int PULSE_W = 7;
    localparam int CFG_W   = 16;
    localparam int REG_IDX_W = 3;

    // Input command codes carried on the slave tuser.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALERT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_AUTO_ON_ENABLE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ON_THRESHOLD_MV   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AUTO_ON_DELAY_MS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FLASH_INTERVAL_MS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FLASH_PULSES      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AC_PRESS_MS       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_AC_BUTTON         = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FLASH_BUTTON      = 3'd7;

    // Register reset values.
    localparam logic [MV_W-1:0]    RST_ON_THRESHOLD_MV   = 16'd20000;
    localparam logic [MS_W-1:0]    RST_AUTO_ON_DELAY_MS  = 16'd5000;
    localparam logic [MS_W-1:0]    RST_FLASH_INTERVAL_MS = 16'd250;
    localparam logic [PULSE_W-1:0] RST_FLASH_PULSES      = 7'd3;
    localparam logic [MS_W-1:0]    RST_AC_PRESS_MS       = 16'd500;
    localparam logic [IDX_W-1:0]   RST_AC_BUTTON         = 3'd4;
    localparam logic [IDX_W-1:0]   RST_FLASH_BUTTON      = 3'd3;

    // Saturation limit of the millisecond counters.
    localparam logic [MS_W-1:0] MS_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== sv/button_pulse_and_auto_on_sequencer_top.sv =====
// Top level of the button pulse and auto power-on sequencer.
// Depends on bpas_pkg for codes, widths and register reset values.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  tuser: cmd; tdata: index, press_ms, battery_mv
//   m_*      out        m_tvalid/m_tready  tdata: lines, accepted, fired, busy flags
//   cfg_*    in         cfg_we             cfg_index selects, cfg_data holds the value
//
// Each transfer is processed in the cycle it is accepted: the state registers
// and the result are updated at the same clock edge, so one item per cycle
// while s_tready is high. The result is registered in the output register; a
// skid register behind it lets one more item in while the output is stalled.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module button_pulse_and_auto_on_sequencer_top #(
    parameter int NUM_BUTTONS = 5
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [2:0] button_index, [18:3] press_ms, [34:19] battery_mv, [39:35] zero
    input  wire logic [39:0]                          s_tdata,
    // [1:0] cmd
    input  wire logic [bpas_pkg::CMD_W-1:0]           s_tuser,

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // button_lines, accepted, auto_on_fired, press_busy, alert_busy, zero fill
    output logic [((NUM_BUTTONS + 4 + 7) / 8) * 8 - 1:0] m_tdata,

    input  wire logic                                 cfg_we,
    input  wire logic [bpas_pkg::REG_IDX_W-1:0]       cfg_index,
    input  wire logic [bpas_pkg::CFG_W-1:0]           cfg_data
);

    localparam int RES_W = NUM_BUTTONS + 4;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;
    localparam int IDX_W = bpas_pkg::IDX_W;
    localparam int MS_W  = bpas_pkg::MS_W;
    localparam int MV_W  = bpas_pkg::MV_W;

    // One-hot line mask for a button index; indexes past the last line give zero.
    function automatic logic [NUM_BUTTONS-1:0] line_bit(input logic [IDX_W-1:0] idx);
        logic [NUM_BUTTONS-1:0] mask;
        mask = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            mask[i] = (idx == IDX_W'(i));
        end
        return mask;
    endfunction

    // Saturating millisecond increment.
    function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
        return (v == bpas_pkg::MS_MAX) ? v : v + MS_W'(1);
    endfunction

    // Configuration registers.
    logic                           auto_on_enable_reg;
    logic [MV_W-1:0]                on_threshold_mv_reg;
    logic [MS_W-1:0]                auto_on_delay_ms_reg;
    logic [MS_W-1:0]                flash_interval_ms_reg;
    logic [bpas_pkg::PULSE_W-1:0]   flash_pulses_reg;
    logic [MS_W-1:0]                ac_press_ms_reg;
    logic [IDX_W-1:0]               ac_button_reg;
    logic [IDX_W-1:0]               flash_button_reg;

    // Sequencer state.
    logic [NUM_BUTTONS-1:0]         line_levels_reg,   line_levels_next;
    logic                           press_active_reg,  press_active_next;
    logic [IDX_W-1:0]               press_button_reg,  press_button_next;
    logic [MS_W-1:0]                press_length_reg,  press_length_next;
    logic [MS_W-1:0]                press_elapsed_reg, press_elapsed_next;
    logic                           alert_active_reg,  alert_active_next;
    logic [bpas_pkg::EDGE_W-1:0]    alert_edges_reg,   alert_edges_next;
    logic [MS_W-1:0]                alert_elapsed_reg, alert_elapsed_next;
    logic                           station_was_off_reg, station_was_off_next;
    logic                           ac_done_reg,       ac_done_next;
    logic [MS_W-1:0]                on_elapsed_reg,    on_elapsed_next;

    // Output and skid registers.
    logic                           out_valid_reg;
    logic [OUT_W-1:0]               out_data_reg;
    logic                           skid_valid_reg;
    logic [OUT_W-1:0]               skid_data_reg;

    // Input fields.
    logic [IDX_W-1:0]               in_idx;
    logic [MS_W-1:0]                in_press_ms;
    logic [MV_W-1:0]                in_mv;
    logic                           in_fire;

    // Helpers for the update logic.
    logic [NUM_BUTTONS-1:0]         idx_mask, press_mask, flash_mask, ac_mask;
    logic [MS_W-1:0]                press_el_inc, alert_el_inc, on_el_inc;
    logic [bpas_pkg::EDGE_W-1:0]    edges_inc, edge_limit;
    logic                           is_on, flash_was_high;
    logic                           accepted, fired;
    logic [RES_W-1:0]               result;

    assign in_idx      = s_tdata[2:0];
    assign in_press_ms = s_tdata[18:3];
    assign in_mv       = s_tdata[34:19];

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign idx_mask     = line_bit(in_idx);
    assign press_mask   = line_bit(press_button_reg);
    assign flash_mask   = line_bit(flash_button_reg);
    assign ac_mask      = line_bit(ac_button_reg);
    assign press_el_inc = sat_inc(press_elapsed_reg);
    assign alert_el_inc = sat_inc(alert_elapsed_reg);
    assign on_el_inc    = sat_inc(on_elapsed_reg);
    assign edges_inc    = alert_edges_reg + bpas_pkg::EDGE_W'(1);
    assign edge_limit   = {flash_pulses_reg, 1'b0};
    assign is_on        = (in_mv >= on_threshold_mv_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_on_enable_reg    <= 1'b0;
            on_threshold_mv_reg   <= bpas_pkg::RST_ON_THRESHOLD_MV;
            auto_on_delay_ms_reg  <= bpas_pkg::RST_AUTO_ON_DELAY_MS;
            flash_interval_ms_reg <= bpas_pkg::RST_FLASH_INTERVAL_MS;
            flash_pulses_reg      <= bpas_pkg::RST_FLASH_PULSES;
            ac_press_ms_reg       <= bpas_pkg::RST_AC_PRESS_MS;
            ac_button_reg         <= bpas_pkg::RST_AC_BUTTON;
            flash_button_reg      <= bpas_pkg::RST_FLASH_BUTTON;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpas_pkg::REG_AUTO_ON_ENABLE:    auto_on_enable_reg    <= cfg_data[0];
                bpas_pkg::REG_ON_THRESHOLD_MV:   on_threshold_mv_reg   <= cfg_data;
                bpas_pkg::REG_AUTO_ON_DELAY_MS:  auto_on_delay_ms_reg  <= cfg_data;
                bpas_pkg::REG_FLASH_INTERVAL_MS: flash_interval_ms_reg <= cfg_data;
                bpas_pkg::REG_FLASH_PULSES:
                    flash_pulses_reg <= cfg_data[bpas_pkg::PULSE_W-1:0];
                bpas_pkg::REG_AC_PRESS_MS:       ac_press_ms_reg       <= cfg_data;
                bpas_pkg::REG_AC_BUTTON:         ac_button_reg    <= cfg_data[IDX_W-1:0];
                bpas_pkg::REG_FLASH_BUTTON:      flash_button_reg <= cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and result for the item in this transfer.
    always_comb
    begin
        line_levels_next     = line_levels_reg;
        press_active_next    = press_active_reg;
        press_button_next    = press_button_reg;
        press_length_next    = press_length_reg;
        press_elapsed_next   = press_elapsed_reg;
        alert_active_next    = alert_active_reg;
        alert_edges_next     = alert_edges_reg;
        alert_elapsed_next   = alert_elapsed_reg;
        station_was_off_next = station_was_off_reg;
        ac_done_next         = ac_done_reg;
        on_elapsed_next      = on_elapsed_reg;
        accepted             = 1'b0;
        fired                = 1'b0;
        flash_was_high       = 1'b0;

        if (in_fire)
        begin
            unique case (s_tuser)
                bpas_pkg::CMD_PRESS:
                begin
                    if ((idx_mask != '0) && !press_active_reg)
                    begin
                        press_active_next  = 1'b1;
                        press_button_next  = in_idx;
                        press_length_next  = in_press_ms;
                        press_elapsed_next = '0;
                        line_levels_next   = line_levels_reg | idx_mask;
                        accepted           = 1'b1;
                    end
                end
                bpas_pkg::CMD_ALERT:
                begin
                    alert_active_next  = 1'b1;
                    alert_edges_next   = '0;
                    alert_elapsed_next = '0;
                    line_levels_next   = line_levels_reg | flash_mask;
                end
                bpas_pkg::CMD_TICK:
                begin
                    // Release a press whose time is up.
                    if (press_active_reg)
                    begin
                        press_elapsed_next = press_el_inc;
                        if (press_el_inc >= press_length_reg)
                        begin
                            line_levels_next   = line_levels_next & ~press_mask;
                            press_active_next  = 1'b0;
                            press_button_next  = '0;
                            press_length_next  = '0;
                            press_elapsed_next = '0;
                        end
                    end
                    // Flashlight toggling; a rising edge may end the alert.
                    if (alert_active_reg)
                    begin
                        alert_elapsed_next = alert_el_inc;
                        if (alert_el_inc >= flash_interval_ms_reg)
                        begin
                            flash_was_high     = |(line_levels_next & flash_mask);
                            line_levels_next   = line_levels_next ^ flash_mask;
                            alert_elapsed_next = '0;
                            if (!flash_was_high)
                            begin
                                alert_edges_next = edges_inc;
                                if (edges_inc >= edge_limit)
                                begin
                                    alert_active_next = 1'b0;
                                    alert_edges_next  = '0;
                                    line_levels_next  = line_levels_next & ~flash_mask;
                                end
                            end
                        end
                    end
                    // Auto power-on: at most one AC press a set delay after the station comes on.
                    on_elapsed_next = on_el_inc;
                    if (auto_on_enable_reg)
                    begin
                        if (is_on && station_was_off_reg)
                        begin
                            on_elapsed_next      = '0;
                            station_was_off_next = 1'b0;
                            ac_done_next         = 1'b0;
                        end
                        if (!is_on && !station_was_off_reg)
                        begin
                            station_was_off_next = 1'b1;
                        end
                        if (is_on && !ac_done_next && !station_was_off_next &&
                            (on_elapsed_next >= auto_on_delay_ms_reg))
                        begin
                            if ((ac_mask != '0) && !press_active_next)
                            begin
                                press_active_next  = 1'b1;
                                press_button_next  = ac_button_reg;
                                press_length_next  = ac_press_ms_reg;
                                press_elapsed_next = '0;
                                line_levels_next   = line_levels_next | ac_mask;
                            end
                            ac_done_next = 1'b1;
                            fired        = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        result = {alert_active_next, press_active_next, fired, accepted, line_levels_next};
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_levels_reg     <= '0;
            press_active_reg    <= 1'b0;
            press_button_reg    <= '0;
            press_length_reg    <= '0;
            press_elapsed_reg   <= '0;
            alert_active_reg    <= 1'b0;
            alert_edges_reg     <= '0;
            alert_elapsed_reg   <= '0;
            station_was_off_reg <= 1'b1;
            ac_done_reg         <= 1'b0;
            on_elapsed_reg      <= '0;
        end
        else
        begin
            line_levels_reg     <= line_levels_next;
            press_active_reg    <= press_active_next;
            press_button_reg    <= press_button_next;
            press_length_reg    <= press_length_next;
            press_elapsed_reg   <= press_elapsed_next;
            alert_active_reg    <= alert_active_next;
            alert_edges_reg     <= alert_edges_next;
            alert_elapsed_reg   <= alert_elapsed_next;
            station_was_off_reg <= station_was_off_next;
            ac_done_reg         <= ac_done_next;
            on_elapsed_reg      <= on_elapsed_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the output and skid registers.
    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= OUT_W'(result);
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= OUT_W'(result);
        end
    end

    // The skid register only ever holds a result behind a valid output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A transfer taken while the output stalls must land in the skid register.
    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost during output stall");

    // An idle press leaves its bookkeeping cleared.
    a_press_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !press_active_reg |-> (press_elapsed_reg == '0 && press_length_reg == '0 &&
                               press_button_reg == '0))
        else $error("press state not cleared while idle");

    // An idle alert leaves its counters cleared.
    a_alert_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !alert_active_reg |-> (alert_edges_reg == '0 && alert_elapsed_reg == '0))
        else $error("alert counters not cleared while idle");

endmodule

`default_nettype wire

// ===== tb/button_pulse_and_auto_on_sequencer_top_tb.sv =====
// Self-checking testbench for the button pulse and auto power-on sequencer.
// Drives ticks, press requests and alerts, and checks every result against a predictor or a table.
// Depends on bpas_pkg and button_pulse_and_auto_on_sequencer_top.
module button_pulse_and_auto_on_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUTTONS     = 5;
    localparam int ITEMS_PER_PHASE = 265;
    localparam int RANDOM_PHASES   = 6;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_AT_ITEM    = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 200000;

    // One input item and one result, as the block sees them.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  button;
        logic [15:0] press_ms;
        logic [15:0] mv;
    } seq_item_t;

    typedef struct packed {
        logic [4:0] lines;
        logic       accepted;
        logic       fired;
        logic       press_busy;
        logic       alert_busy;
    } line_report_t;

    // One step of the directed part: a register write or an item.
    typedef struct packed {
        logic         is_write;
        logic [2:0]   reg_sel;
        logic [15:0]  reg_val;
        seq_item_t    item;
        logic         known;
        line_report_t want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    button_pulse_and_auto_on_sequencer_top #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the register file, at reset values.
    logic        cfg_auto_on     = 1'b0;
    logic [15:0] cfg_threshold   = bpas_pkg::RST_ON_THRESHOLD_MV;
    logic [15:0] cfg_delay       = bpas_pkg::RST_AUTO_ON_DELAY_MS;
    logic [15:0] cfg_interval    = bpas_pkg::RST_FLASH_INTERVAL_MS;
    logic [6:0]  cfg_pulses      = bpas_pkg::RST_FLASH_PULSES;
    logic [15:0] cfg_ac_press    = bpas_pkg::RST_AC_PRESS_MS;
    logic [2:0]  cfg_ac_button   = bpas_pkg::RST_AC_BUTTON;
    logic [2:0]  cfg_flash_btn   = bpas_pkg::RST_FLASH_BUTTON;

    // Shadow copy of the sequencer state, at reset values.
    logic [4:0]  lv          = '0;
    logic        pr_active   = 1'b0;
    logic [2:0]  pr_button   = '0;
    logic [15:0] pr_len      = '0;
    logic [15:0] pr_elapsed  = '0;
    logic        al_active   = 1'b0;
    logic [7:0]  al_edges    = '0;
    logic [15:0] al_elapsed  = '0;
    logic        stn_off     = 1'b1;
    logic        ac_done     = 1'b0;
    logic [15:0] on_elapsed  = '0;

    line_report_t pending_reports[$];
    plan_row_t    plan[$];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    int           reports_seen   = 0;
    int           burst_left     = 0;
    int           cycle_count    = 0;
    logic         mains_on       = 1'b0;

    function automatic logic [4:0] line_mask(logic [2:0] idx);
        logic [4:0] m;
        m = '0;
        if (idx < NUM_BUTTONS)
            m[idx] = 1'b1;
        return m;
    endfunction

    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == bpas_pkg::MS_MAX) ? v : v + 16'd1;
    endfunction

    // Start a press on one line unless the index is bad or a press is running.
    function automatic logic try_press(logic [2:0] idx, logic [15:0] len);
        if (idx >= NUM_BUTTONS || pr_active)
            return 1'b0;
        pr_active  = 1'b1;
        pr_button  = idx;
        pr_len     = len;
        pr_elapsed = '0;
        lv         = lv | line_mask(idx);
        return 1'b1;
    endfunction

    function automatic void set_reg(logic [2:0] sel, logic [15:0] val);
        case (sel)
            bpas_pkg::REG_AUTO_ON_ENABLE:    cfg_auto_on   = val[0];
            bpas_pkg::REG_ON_THRESHOLD_MV:   cfg_threshold = val;
            bpas_pkg::REG_AUTO_ON_DELAY_MS:  cfg_delay     = val;
            bpas_pkg::REG_FLASH_INTERVAL_MS: cfg_interval  = val;
            bpas_pkg::REG_FLASH_PULSES:      cfg_pulses    = val[6:0];
            bpas_pkg::REG_AC_PRESS_MS:       cfg_ac_press  = val;
            bpas_pkg::REG_AC_BUTTON:         cfg_ac_button = val[2:0];
            bpas_pkg::REG_FLASH_BUTTON:      cfg_flash_btn = val[2:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow state by one item and return the line report it yields.
    function automatic line_report_t advance_sequencer(seq_item_t it);
        line_report_t r;
        logic [4:0]   fb;
        logic         was_high;
        logic         is_on;
        r = '0;
        case (it.cmd)
            bpas_pkg::CMD_PRESS:
                r.accepted = try_press(it.button, it.press_ms);
            bpas_pkg::CMD_ALERT:
            begin
                al_active  = 1'b1;
                al_edges   = '0;
                al_elapsed = '0;
                lv         = lv | line_mask(cfg_flash_btn);
            end
            bpas_pkg::CMD_TICK:
            begin
                // Release a press whose time is up.
                if (pr_active)
                begin
                    pr_elapsed = sat_inc16(pr_elapsed);
                    if (pr_elapsed >= pr_len)
                    begin
                        lv         = lv & ~line_mask(pr_button);
                        pr_active  = 1'b0;
                        pr_button  = '0;
                        pr_len     = '0;
                        pr_elapsed = '0;
                    end
                end
                // Toggle the flashlight line and count its rising edges.
                if (al_active)
                begin
                    al_elapsed = sat_inc16(al_elapsed);
                    if (al_elapsed >= cfg_interval)
                    begin
                        fb         = line_mask(cfg_flash_btn);
                        was_high   = |(lv & fb);
                        lv         = lv ^ fb;
                        al_elapsed = '0;
                        if (!was_high)
                        begin
                            al_edges = al_edges + 8'd1;
                            if (al_edges >= {cfg_pulses, 1'b0})
                            begin
                                al_active  = 1'b0;
                                al_edges   = '0;
                                al_elapsed = '0;
                                lv         = lv & ~fb;
                            end
                        end
                    end
                end
                // Auto power-on: at most one AC press after the station comes up.
                on_elapsed = sat_inc16(on_elapsed);
                if (cfg_auto_on)
                begin
                    is_on = it.mv >= cfg_threshold;
                    if (is_on && stn_off)
                    begin
                        on_elapsed = '0;
                        stn_off    = 1'b0;
                        ac_done    = 1'b0;
                    end
                    if (!is_on && !stn_off)
                        stn_off = 1'b1;
                    if (is_on && !ac_done && !stn_off && on_elapsed >= cfg_delay)
                    begin
                        void'(try_press(cfg_ac_button, cfg_ac_press));
                        ac_done = 1'b1;
                        r.fired = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.lines      = lv;
        r.press_busy = pr_active;
        r.alert_busy = al_active;
        return r;
    endfunction

    // Mostly ticks with a battery level that stays on one side of the threshold
    // for a while, so that the auto power-on delay can run out.
    function automatic seq_item_t make_random_item();
        seq_item_t it;
        int        pick;
        it.cmd      = bpas_pkg::CMD_TICK;
        it.button   = 3'($urandom_range(0, 7));
        it.press_ms = 16'($urandom);
        it.mv       = 16'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 68)
        begin
            if ($urandom_range(0, 49) == 0)
                mains_on = !mains_on;
            if ($urandom_range(0, 19) != 0)
            begin
                if (mains_on)
                    it.mv = 16'($urandom_range(cfg_threshold, 16'hFFFF));
                else if (cfg_threshold != 0)
                    it.mv = 16'($urandom_range(0, cfg_threshold - 1));
            end
        end
        else if (pick < 84)
        begin
            it.cmd = bpas_pkg::CMD_PRESS;
            if ($urandom_range(0, 4) != 0)
                it.button = 3'($urandom_range(0, NUM_BUTTONS - 1));
            // Long presses only where they get rejected, or the lines lock up.
            if (!pr_active && it.button < NUM_BUTTONS)
                it.press_ms = 16'($urandom_range(0, 12));
        end
        else if (pick < 95)
            it.cmd = bpas_pkg::CMD_ALERT;
        else
            it.cmd = bpas_pkg::CMD_NONE;
        return it;
    endfunction

    function automatic plan_row_t write_row(logic [2:0] sel, logic [15:0] val);
        plan_row_t p;
        p          = '0;
        p.is_write = 1'b1;
        p.reg_sel  = sel;
        p.reg_val  = val;
        return p;
    endfunction

    function automatic plan_row_t stim_row(logic [1:0] cmd, logic [2:0] button,
                                           logic [15:0] press_ms, logic [15:0] mv);
        plan_row_t p;
        p               = '0;
        p.item.cmd      = cmd;
        p.item.button   = button;
        p.item.press_ms = press_ms;
        p.item.mv       = mv;
        return p;
    endfunction

    function automatic plan_row_t known_row(logic [1:0] cmd, logic [2:0] button,
                                            logic [15:0] press_ms, logic [15:0] mv,
                                            logic [4:0] lines, logic acc, logic fired,
                                            logic pbusy, logic abusy);
        plan_row_t p;
        p                 = stim_row(cmd, button, press_ms, mv);
        p.known           = 1'b1;
        p.want.lines      = lines;
        p.want.accepted   = acc;
        p.want.fired      = fired;
        p.want.press_busy = pbusy;
        p.want.alert_busy = abusy;
        return p;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(posedge clk);
        set_reg(sel, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offer one item in bursts with random gaps, and predict it on its transfer.
    task automatic offer(input seq_item_t it, input logic use_known,
                         input line_report_t known);
        int           gap;
        line_report_t predicted;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = it.cmd;
        s_tdata  = {5'b0, it.mv, it.press_ms, it.button};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_sequencer(it);
        pending_reports.push_back(use_known ? known : predicted);
        burst_left--;
        items_sent++;
    endtask

    // Stop offering and let every expected report come out before a register write.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int n,
                               input logic [4:0] want, input logic [4:0] got);
        if (got !== want)
            note_failure($sformatf("report %0d %s: expected %h, got %h", n, name, want, got));
    endtask

    // Clock, period 4 ns.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Compare each report transfer with the oldest expectation.
    always @(posedge clk)
    begin
        line_report_t want;
        line_report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.lines      = m_tdata[4:0];
            got.accepted   = m_tdata[5];
            got.fired      = m_tdata[6];
            got.press_busy = m_tdata[7];
            got.alert_busy = m_tdata[8];
            if (pending_reports.size() == 0)
                note_failure($sformatf("report %0d arrived with nothing expected", reports_seen));
            else
            begin
                want = pending_reports.pop_front();
                check_field("button_lines", reports_seen, want.lines, got.lines);
                check_field("accepted", reports_seen, 5'(want.accepted), 5'(got.accepted));
                check_field("auto_on_fired", reports_seen, 5'(want.fired), 5'(got.fired));
                check_field("press_busy", reports_seen, 5'(want.press_busy),
                            5'(got.press_busy));
                check_field("alert_busy", reports_seen, 5'(want.alert_busy),
                            5'(got.alert_busy));
            end
            reports_seen++;
        end
    end

    // Receiver: ready patterns that change now and then, plus one long hold-off
    // while the sender keeps offering, so that the block backs up.
    initial
    begin
        int   mode;
        int   mode_left;
        int   phase_cnt;
        logic hold_done;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        phase_cnt = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 1) == 0);
                2:       m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = (phase_cnt % 3 != 0);
            endcase
        end
    end

    // Sender: reset, directed table, then random phases under several settings.
    initial
    begin
        logic unsettled;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = bpas_pkg::CMD_TICK;
        cfg_we    = 1'b0;
        cfg_index = bpas_pkg::REG_AUTO_ON_ENABLE;
        cfg_data  = '0;
        unsettled = 1'b0;

        // Register defaults apply to the first rows.
        plan.push_back(known_row(bpas_pkg::CMD_NONE, 3'd7, 16'hFFFF, 16'hFFFF,
                                 5'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        plan.push_back(known_row(bpas_pkg::CMD_TICK, 3'd0, 16'h0000, 16'h0000,
                                 5'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        // Bad button indexes are turned away.
        plan.push_back(known_row(bpas_pkg::CMD_PRESS, 3'd7, 16'hFFFF, 16'h0000,
                                 5'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        plan.push_back(known_row(bpas_pkg::CMD_PRESS, 3'd5, 16'd3, 16'h0000,
                                 5'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        // Zero-length press, then a request while it is still held.
        plan.push_back(known_row(bpas_pkg::CMD_PRESS, 3'd0, 16'd0, 16'h0000,
                                 5'h01, 1'b1, 1'b0, 1'b1, 1'b0));
        plan.push_back(known_row(bpas_pkg::CMD_PRESS, 3'd1, 16'hFFFF, 16'hFFFF,
                                 5'h01, 1'b0, 1'b0, 1'b1, 1'b0));
        plan.push_back(known_row(bpas_pkg::CMD_TICK, 3'd0, 16'h0000, 16'hFFFF,
                                 5'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        plan.push_back(known_row(bpas_pkg::CMD_PRESS, 3'd4, 16'd3, 16'h0000,
                                 5'h10, 1'b1, 1'b0, 1'b1, 1'b0));
        // Alert on the line that is being pressed, toggling on every tick.
        plan.push_back(write_row(bpas_pkg::REG_FLASH_INTERVAL_MS, 16'd0));
        plan.push_back(write_row(bpas_pkg::REG_FLASH_PULSES, 16'd1));
        plan.push_back(write_row(bpas_pkg::REG_FLASH_BUTTON, 16'd4));
        plan.push_back(known_row(bpas_pkg::CMD_ALERT, 3'd0, 16'd0, 16'h0000,
                                 5'h10, 1'b0, 1'b0, 1'b1, 1'b1));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_ALERT, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        // No pulses and a flashlight line that does not exist.
        plan.push_back(write_row(bpas_pkg::REG_FLASH_PULSES, 16'd0));
        plan.push_back(write_row(bpas_pkg::REG_FLASH_BUTTON, 16'd7));
        plan.push_back(stim_row(bpas_pkg::CMD_ALERT, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        // Auto power-on with no delay onto a line that does not exist.
        plan.push_back(write_row(bpas_pkg::REG_AUTO_ON_ENABLE, 16'd1));
        plan.push_back(write_row(bpas_pkg::REG_ON_THRESHOLD_MV, 16'hFFFF));
        plan.push_back(write_row(bpas_pkg::REG_AUTO_ON_DELAY_MS, 16'd0));
        plan.push_back(write_row(bpas_pkg::REG_AC_BUTTON, 16'd5));
        plan.push_back(write_row(bpas_pkg::REG_AC_PRESS_MS, 16'd0));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'hFFFE));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'hFFFF));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        // Auto press while a manual press holds the lines, then disabled.
        plan.push_back(write_row(bpas_pkg::REG_ON_THRESHOLD_MV, 16'd0));
        plan.push_back(write_row(bpas_pkg::REG_AC_BUTTON, 16'd0));
        plan.push_back(write_row(bpas_pkg::REG_AC_PRESS_MS, 16'd2));
        plan.push_back(stim_row(bpas_pkg::CMD_PRESS, 3'd2, 16'd5, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        plan.push_back(write_row(bpas_pkg::REG_AUTO_ON_ENABLE, 16'd0));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'h0000));
        plan.push_back(stim_row(bpas_pkg::CMD_TICK, 3'd0, 16'd0, 16'hFFFF));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (unsettled)
                    settle();
                unsettled = 1'b0;
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end
            else
            begin
                offer(plan[i].item, plan[i].known, plan[i].want);
                unsettled = 1'b1;
            end
        end

        // Random phases: registers at their minimum with auto power-on enabled, then random, then maximum.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            if (ph == 0)
            begin
                write_reg(bpas_pkg::REG_AUTO_ON_ENABLE, 16'd1);
                write_reg(bpas_pkg::REG_ON_THRESHOLD_MV, 16'd0);
                write_reg(bpas_pkg::REG_AUTO_ON_DELAY_MS, 16'd0);
                write_reg(bpas_pkg::REG_FLASH_INTERVAL_MS, 16'd0);
                write_reg(bpas_pkg::REG_FLASH_PULSES, 16'd0);
                write_reg(bpas_pkg::REG_AC_PRESS_MS, 16'd0);
                write_reg(bpas_pkg::REG_AC_BUTTON, 16'd0);
                write_reg(bpas_pkg::REG_FLASH_BUTTON, 16'd0);
            end
            else if (ph == RANDOM_PHASES - 1)
            begin
                write_reg(bpas_pkg::REG_AUTO_ON_ENABLE, 16'd1);
                write_reg(bpas_pkg::REG_ON_THRESHOLD_MV, 16'hFFFF);
                write_reg(bpas_pkg::REG_AUTO_ON_DELAY_MS, 16'hFFFF);
                write_reg(bpas_pkg::REG_FLASH_INTERVAL_MS, 16'hFFFF);
                write_reg(bpas_pkg::REG_FLASH_PULSES, 16'd127);
                write_reg(bpas_pkg::REG_AC_PRESS_MS, 16'hFFFF);
                write_reg(bpas_pkg::REG_AC_BUTTON, 16'd7);
                write_reg(bpas_pkg::REG_FLASH_BUTTON, 16'd7);
            end
            else
            begin
                write_reg(bpas_pkg::REG_AUTO_ON_ENABLE, 16'($urandom_range(0, 3) != 0));
                write_reg(bpas_pkg::REG_ON_THRESHOLD_MV, 16'($urandom));
                write_reg(bpas_pkg::REG_AUTO_ON_DELAY_MS, 16'($urandom_range(0, 40)));
                write_reg(bpas_pkg::REG_FLASH_INTERVAL_MS, 16'($urandom_range(0, 6)));
                write_reg(bpas_pkg::REG_FLASH_PULSES, 16'($urandom_range(0, 5)));
                write_reg(bpas_pkg::REG_AC_PRESS_MS, 16'($urandom_range(0, 15)));
                write_reg(bpas_pkg::REG_AC_BUTTON, 16'($urandom_range(0, 7)));
                write_reg(bpas_pkg::REG_FLASH_BUTTON, 16'($urandom_range(0, 7)));
            end
            repeat (ITEMS_PER_PHASE)
                offer(make_random_item(), 1'b0, '0);
        end

        // Wait for the last reports, then let the block idle before the final check.
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (pending_reports.size() != 0)
            note_failure("expected reports left over at the end");

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
